// ===== rtl/core/hncs_pkg.sv =====
// shared constants and types for the hamming nearest-class search unit
package hncs_pkg;

    // field widths
    localparam int WORD_W  = 32;
    localparam int CLASS_W = 6;
    localparam int DIST_W  = 16;
    localparam int POP_W   = $clog2(WORD_W + 1);

    // compared bits per word and class capacity
    localparam int WORD_BITS   = 32;
    localparam int MAX_CLASSES = 64;
    localparam int CLASS_SPAN  = 1 << CLASS_W;
    localparam int CLASS_LIMIT = (MAX_CLASSES < CLASS_SPAN) ? MAX_CLASSES : CLASS_SPAN;

    // mask of the compared low bits of a word
    localparam logic [WORD_W-1:0] WORD_MASK =
        (WORD_BITS >= WORD_W) ? {WORD_W{1'b1}}
                              : WORD_W'((64'd1 << WORD_BITS) - 64'd1);

    // saturation value of a distance
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [CLASS_W-1:0] t_class;
    typedef logic [DIST_W-1:0]  t_dist;

endpackage

// ===== rtl/core/hncs_dist.sv =====
// popcount of the word difference added to the running distance, saturating
module hncs_dist
    import hncs_pkg::*;
(
    input  t_word i_query_word,
    input  t_word i_class_word,
    input  t_dist i_running,
    output t_dist o_next_running
);

    t_word              diff;
    logic [POP_W-1:0]   ones;
    logic [DIST_W:0]    sum;

    // bits that differ in the compared part of the word
    assign diff = (i_query_word ^ i_class_word) & WORD_MASK;
    assign ones = POP_W'($countones(diff));

    // accumulate and clamp at the top of the range
    assign sum            = {1'b0, i_running} + (DIST_W + 1)'(ones);
    assign o_next_running = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

endmodule

// ===== rtl/core/hamming_nearest_class_search_unit.sv =====
// Hamming-distance nearest-class search over streamed hypervector words.
// Each transaction carries one query word and the matching class word; the unit
// takes one transaction per clock. A transaction is held in an input register,
// then a single stage does the 32-bit popcount, the saturating add to the
// running distance and the compare against the best class so far, and writes the
// search state. The word that carries both last marks leaves a result in the output
// register when it leaves the input register; only a result that waits for the
// consumer holds up the next such word, so the rate is one word per cycle while
// the output side keeps up. Ties keep the earlier class; classes beyond the class
// limit still accumulate but cannot win, and the result reports class_overflow.
module hamming_nearest_class_search_unit
    import hncs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    // input channel
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_word  i_query_word,
    input  t_word  i_class_word,
    input  logic   i_last_word,
    input  logic   i_last_class,
    // result channel
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output t_class o_best_class,
    output t_dist  o_best_distance,
    output logic   o_class_overflow
);

    // input register
    logic   r_s1_valid;
    t_word  r_query_word;
    t_word  r_class_word;
    logic   r_last_word;
    logic   r_last_class;

    // search state
    t_dist  r_running, n_running;
    t_dist  r_smallest, n_smallest;
    t_class r_winner, n_winner;
    t_class r_counter, n_counter;
    logic   r_first, n_first;
    logic   r_ovf, n_ovf;

    // result register
    logic   r_out_valid;
    t_class r_best_class;
    t_dist  r_best_distance;
    logic   r_class_overflow;

    t_dist  acc_dist;
    logic   s1_result;
    logic   s1_fire;
    logic   s1_take;
    logic   in_fire;
    logic   [CLASS_W:0] counter_inc;

    // distance of the class in progress including this word
    hncs_dist u_dist (
        .i_query_word   (r_query_word),
        .i_class_word   (r_class_word),
        .i_running      (r_running),
        .o_next_running (acc_dist)
    );

    // stage handshake: the stage waits only when it has a result and the output is held
    assign s1_result  = r_s1_valid && r_last_word && r_last_class;
    assign s1_fire    = r_s1_valid && (!s1_result || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    // unless past the limit, the ending class becomes the winner: first or strictly smaller
    assign s1_take = !r_ovf && (r_first || (acc_dist < r_smallest));

    assign counter_inc = {1'b0, r_counter} + (CLASS_W + 1)'(1);

    // next search state
    always_comb begin
        n_running  = r_running;
        n_smallest = r_smallest;
        n_winner   = r_winner;
        n_counter  = r_counter;
        n_first    = r_first;
        n_ovf      = r_ovf;
        if (s1_fire) begin
            n_running = acc_dist;
            if (r_last_word) begin
                // class end: compete unless past the class limit
                if (!r_ovf) begin
                    if (s1_take) begin
                        n_smallest = acc_dist;
                        n_winner   = r_counter;
                    end
                    n_first = 1'b0;
                end
                n_running = '0;
                if (r_last_class) begin
                    n_running  = '0;
                    n_smallest = '0;
                    n_winner   = '0;
                    n_counter  = '0;
                    n_first    = 1'b1;
                    n_ovf      = 1'b0;
                end else if (counter_inc >= (CLASS_W + 1)'(CLASS_LIMIT)) begin
                    n_ovf = 1'b1;
                end else begin
                    n_counter = counter_inc[CLASS_W-1:0];
                end
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
        if (in_fire) begin
            r_query_word <= i_query_word;
            r_class_word <= i_class_word;
            r_last_word  <= i_last_word;
            r_last_class <= i_last_class;
        end
    end

    // search state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running  <= '0;
            r_smallest <= '0;
            r_winner   <= '0;
            r_counter  <= '0;
            r_first    <= 1'b1;
            r_ovf      <= 1'b0;
        end else begin
            r_running  <= n_running;
            r_smallest <= n_smallest;
            r_winner   <= n_winner;
            r_counter  <= n_counter;
            r_first    <= n_first;
            r_ovf      <= n_ovf;
        end
    end

    // result register: winner after the final class has competed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && s1_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_fire && s1_result) begin
            r_best_class     <= s1_take ? r_counter : r_winner;
            r_best_distance  <= s1_take ? acc_dist : r_smallest;
            r_class_overflow <= r_ovf;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_best_class     = r_best_class;
    assign o_best_distance  = r_best_distance;
    assign o_class_overflow = r_class_overflow;

`ifndef SYNTHESIS
    // a fresh search has no progress recorded
    a_fresh_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first |-> (r_counter == '0) && !r_ovf && (r_winner == '0) && (r_smallest == '0))
        else $error("fresh search carries stale state");

    // overflow only once the counter sits at its limit
    a_ovf_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_counter == CLASS_W'(CLASS_LIMIT - 1)))
        else $error("overflow flagged below the class limit");

    // the winner is never a class that has not been seen
    a_winner_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_winner <= r_counter)
        else $error("winner index ahead of class counter");

    // a completed search always leaves a result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && s1_result |=> o_out_valid && r_first)
        else $error("search end produced no result");
`endif

endmodule
